// ===== hdl/ordered_array_list_engine_unit_assert.svh =====
// Assertion shorthands used by the checker file.
// Each macro expects clk_i and rst_ni to exist in the scope where it is used.
`ifndef ORDERED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define OALE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered table check failed");

// Next-cycle implication.
`define OALE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered table check failed");

`endif

// ===== hdl/oale_pkg.sv =====
package oale_pkg;

  // Operation codes carried in the request.
  localparam logic [2:0] OP_READ       = 3'd0;
  localparam logic [2:0] OP_GROW_READ  = 3'd1;
  localparam logic [2:0] OP_GROW_WRITE = 3'd2;
  localparam logic [2:0] OP_INSERT     = 3'd3;
  localparam logic [2:0] OP_REMOVE     = 3'd4;
  localparam logic [2:0] OP_FIND       = 3'd5;
  localparam logic [2:0] OP_CLEAR      = 3'd6;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_MISS  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  index;
    logic [31:0] value;
  } oale_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [7:0]  found_index;
    logic [8:0]  used_count;
  } oale_rsp_t;

endpackage

// ===== hdl/oale_chan_if.sv =====
interface oale_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, input ready, output payload);
  modport sink   (input valid, output ready, input payload);
endinterface

// ===== hdl/ordered_array_list_engine_unit.sv =====
// Ordered table engine: DEPTH words of WORD_BITS each, plus a count of used entries.
// Requests arrive on req_i (opcode, index, value) and each one produces exactly one
// response on rsp_o (status, read_value, found_index, used_count), in request order.
// Both channels use a valid/ready handshake; a transfer happens when both are high.
// After reset the table memory is swept to zero, one word per cycle, and req_i.ready
// stays low during the sweep; the used count is zero when the sweep ends.
// Clear, grow-write, unused-opcode and rejected requests go from execution straight to the done
// state; read and grow-read pass through a read-wait state first. Insert and remove
// move one word per cycle through the single-port-read memory, and find scans one
// word per cycle, comparing each word after it is fetched, until it finds a match
// or reaches the used count.
// The memory read port sets this pace: one word is fetched per cycle.
// One request is in progress at a time. A new request can be taken in the cycle after the
// previous response is placed in the output register, even while that response is
// still waiting for rsp_o.ready. If the receiver stalls, the finished response of the
// following request waits inside the engine until the output register frees up.
module ordered_array_list_engine_unit #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  oale_chan_if.sink    req_i,
  oale_chan_if.source  rsp_o
);

  localparam int AW = $clog2(DEPTH);       // memory address width
  localparam int CW = $clog2(DEPTH + 1);   // used count width, holds DEPTH itself
  localparam int XW = CW + 9;              // common width for index/count compares

  // Sequencer states.
  localparam logic [2:0] S_CLEAR      = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_EXEC       = 3'd2;
  localparam logic [2:0] S_READ_WAIT  = 3'd3;
  localparam logic [2:0] S_SHIFT_UP   = 3'd4;
  localparam logic [2:0] S_SHIFT_DOWN = 3'd5;
  localparam logic [2:0] S_FIND       = 3'd6;
  localparam logic [2:0] S_DONE       = 3'd7;

  // Table memory, one read and one write port, registered read data.
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] mem_rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  // Control state.
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          wr_pend_q, wr_pend_d;
  logic          cmp_pend_q, cmp_pend_d;
  logic          out_valid_q, out_valid_d;

  // Request and result holding registers.
  logic [2:0]           op_q, op_d;
  logic [7:0]           idx_q, idx_d;
  logic [WORD_BITS-1:0] val_q, val_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;
  logic [AW-1:0]        cmp_addr_q, cmp_addr_d;
  logic [1:0]           res_status_q, res_status_d;
  logic [31:0]          res_rdata_q, res_rdata_d;
  logic [7:0]           res_fidx_q, res_fidx_d;
  oale_pkg::oale_rsp_t  out_q, out_d;

  logic [XW-1:0] idx_x, cnt_x, ptr_x;
  logic [CW-1:0] grow_cnt;
  logic          req_fire;

  assign idx_x    = XW'(idx_q);
  assign cnt_x    = XW'(count_q);
  assign ptr_x    = XW'(ptr_q);
  assign grow_cnt = CW'(idx_x + XW'(1));
  assign req_fire = req_i.valid && req_i.ready;

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    wr_pend_d    = wr_pend_q;
    cmp_pend_d   = cmp_pend_q;
    op_d         = op_q;
    idx_d        = idx_q;
    val_d        = val_q;
    wr_addr_d    = wr_addr_q;
    cmp_addr_d   = cmp_addr_q;
    res_status_d = res_status_q;
    res_rdata_d  = res_rdata_q;
    res_fidx_d   = res_fidx_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;

    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = mem_rdata_q;
    mem_re    = 1'b0;
    mem_raddr = AW'(ptr_q);

    unique case (state_q)
      S_CLEAR: begin
        // Zero one word per cycle after reset.
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_q);
        mem_wdata = '0;
        ptr_d     = ptr_q + CW'(1);
        if (ptr_q == CW'(DEPTH - 1)) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          op_d    = req_i.payload.opcode;
          idx_d   = req_i.payload.index;
          val_d   = WORD_BITS'(req_i.payload.value);
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = oale_pkg::STATUS_OK;
        res_rdata_d  = '0;
        res_fidx_d   = '0;
        state_d      = S_DONE;
        unique case (op_q) inside
          oale_pkg::OP_READ: begin
            if (idx_x < cnt_x) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(idx_q);
              state_d   = S_READ_WAIT;
            end else begin
              res_status_d = oale_pkg::STATUS_RANGE;
            end
          end
          oale_pkg::OP_GROW_READ, oale_pkg::OP_GROW_WRITE: begin
            if (idx_x >= XW'(DEPTH)) begin
              res_status_d = oale_pkg::STATUS_RANGE;
            end else begin
              if (count_q < grow_cnt) begin
                count_d = grow_cnt;
              end
              if (op_q == oale_pkg::OP_GROW_READ) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(idx_q);
                state_d   = S_READ_WAIT;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_q);
                mem_wdata = val_q;
              end
            end
          end
          oale_pkg::OP_INSERT: begin
            if (idx_x > cnt_x) begin
              res_status_d = oale_pkg::STATUS_RANGE;
            end else if (cnt_x >= XW'(DEPTH)) begin
              res_status_d = oale_pkg::STATUS_FULL;
            end else begin
              ptr_d     = count_q;
              wr_pend_d = 1'b0;
              state_d   = S_SHIFT_UP;
            end
          end
          oale_pkg::OP_REMOVE: begin
            if (idx_x >= cnt_x) begin
              res_status_d = oale_pkg::STATUS_RANGE;
            end else begin
              ptr_d     = grow_cnt;
              wr_pend_d = 1'b0;
              state_d   = S_SHIFT_DOWN;
            end
          end
          oale_pkg::OP_FIND: begin
            ptr_d      = '0;
            cmp_pend_d = 1'b0;
            state_d    = S_FIND;
          end
          oale_pkg::OP_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_READ_WAIT: begin
        res_rdata_d = 32'(mem_rdata_q);
        state_d     = S_DONE;
      end

      S_SHIFT_UP: begin
        // Read word ptr-1 now, write it to ptr next cycle, walking downward.
        mem_we = wr_pend_q;
        if (ptr_x > idx_x) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_q - CW'(1));
          wr_pend_d = 1'b1;
          wr_addr_d = AW'(ptr_q);
          ptr_d     = ptr_q - CW'(1);
        end else if (!wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_q);
          mem_wdata = val_q;
          count_d   = count_q + CW'(1);
          state_d   = S_DONE;
        end else begin
          wr_pend_d = 1'b0;
        end
      end

      S_SHIFT_DOWN: begin
        // Read word ptr now, write it to ptr-1 next cycle, walking upward.
        mem_we = wr_pend_q;
        if (ptr_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_q);
          wr_pend_d = 1'b1;
          wr_addr_d = AW'(ptr_q - CW'(1));
          ptr_d     = ptr_q + CW'(1);
        end else if (!wr_pend_q) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          wr_pend_d = 1'b0;
        end
      end

      S_FIND: begin
        // Fetch one word per cycle and compare it in the next cycle.
        if (cmp_pend_q && (mem_rdata_q == val_q)) begin
          res_fidx_d = 8'(cmp_addr_q);
          cmp_pend_d = 1'b0;
          state_d    = S_DONE;
        end else if (ptr_q < count_q) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(ptr_q);
          cmp_pend_d = 1'b1;
          cmp_addr_d = AW'(ptr_q);
          ptr_d      = ptr_q + CW'(1);
        end else begin
          res_status_d = oale_pkg::STATUS_MISS;
          cmp_pend_d   = 1'b0;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d.status      = res_status_q;
          out_d.read_value  = res_rdata_q;
          out_d.found_index = res_fidx_q;
          out_d.used_count  = 9'(count_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      count_q     <= '0;
      ptr_q       <= '0;
      wr_pend_q   <= 1'b0;
      cmp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      wr_pend_q   <= wr_pend_d;
      cmp_pend_q  <= cmp_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    val_q        <= val_d;
    wr_addr_q    <= wr_addr_d;
    cmp_addr_q   <= cmp_addr_d;
    res_status_q <= res_status_d;
    res_rdata_q  <= res_rdata_d;
    res_fidx_q   <= res_fidx_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

endmodule

// ===== hdl/oale_checker.sv =====
`include "ordered_array_list_engine_unit_assert.svh"

module oale_checker #(
  parameter int DEPTH = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] read_value_i,
  input logic [7:0]  found_index_i,
  input logic [8:0]  used_count_i
);

  logic [50:0] rsp_word;
  logic        read_ok;

  assign rsp_word = {status_i, read_value_i, found_index_i, used_count_i};
  assign read_ok  = (status_i == oale_pkg::STATUS_OK) && (found_index_i == 8'd0);

  // A stalled response must not change under the receiver.
  `OALE_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_word))

  // The used count reported never exceeds the table depth.
  `OALE_ASSERT_NOW(a_count_bound, rsp_valid_i, 32'(used_count_i) <= 32'(DEPTH))

  // A nonzero read word only comes with a successful read, which reports no match index.
  `OALE_ASSERT_NOW(a_read_clean, rsp_valid_i && (read_value_i != 32'd0), read_ok)

  // No response can appear in the cycle right after a request is taken.
  `OALE_ASSERT_NEXT(a_min_latency, req_valid_i && req_ready_i && !rsp_valid_i, !rsp_valid_i)

endmodule

bind ordered_array_list_engine_unit oale_checker #(
  .DEPTH(DEPTH)
) u_oale_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.payload.status),
  .read_value_i (rsp_o.payload.read_value),
  .found_index_i(rsp_o.payload.found_index),
  .used_count_i (rsp_o.payload.used_count)
);

// ===== tb/sv/ordered_array_list_engine_unit_test.sv =====
`timescale 1ns / 1ps

module ordered_array_list_engine_unit_test;

  localparam int TABLE_DEPTH = 256;
  localparam int WORD_WIDTH = 32;
  // Opcode 7 has no name in the package; the engine must treat it as a no-op.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  // Cycles with no request or response moving before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the long receiver hold-off used to fill the engine.
  localparam int HOLD_OFF_CYCLES = 300;
  // Quiet time after the last response, longer than the slowest operation.
  localparam int SETTLE_CYCLES = 300;

  logic clk_i;
  logic rst_ni;

  oale_chan_if #(.payload_t(oale_pkg::oale_req_t)) req_if ();
  oale_chan_if #(.payload_t(oale_pkg::oale_rsp_t)) rsp_if ();

  ordered_array_list_engine_unit #(
    .DEPTH(TABLE_DEPTH),
    .WORD_BITS(WORD_WIDTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the table, updated when a request is accepted.
  logic [WORD_WIDTH-1:0] table_words [TABLE_DEPTH];
  int unsigned           table_used;

  oale_pkg::oale_rsp_t expected_rsps[$];
  int                  error_count;
  int                  rsp_number;

  // Sender pacing: bursts of requests separated by random gaps.
  bit sender_gaps_on;
  int burst_left;

  // Receiver controls, written by the tests with nonblocking assignments.
  int rsp_stall_pct;
  int hold_off_seq;

  logic [WORD_WIDTH-1:0] value_pool [8];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR: %s", msg);
  endtask

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic oale_pkg::oale_rsp_t apply_table_op(input oale_pkg::oale_req_t req);
    oale_pkg::oale_rsp_t res;
    int unsigned         idx;
    int unsigned         i;
    res = '0;
    idx = 32'(req.index);
    case (req.opcode) inside
      oale_pkg::OP_READ: begin
        if (idx < table_used) res.read_value = table_words[idx];
        else res.status = oale_pkg::STATUS_RANGE;
      end
      oale_pkg::OP_GROW_READ, oale_pkg::OP_GROW_WRITE: begin
        if (idx >= TABLE_DEPTH) begin
          res.status = oale_pkg::STATUS_RANGE;
        end else begin
          if (table_used < idx + 1) table_used = idx + 1;
          if (req.opcode == oale_pkg::OP_GROW_READ) res.read_value = table_words[idx];
          else table_words[idx] = req.value;
        end
      end
      oale_pkg::OP_INSERT: begin
        // The range check wins over the full check.
        if (idx > table_used) begin
          res.status = oale_pkg::STATUS_RANGE;
        end else if (table_used >= TABLE_DEPTH) begin
          res.status = oale_pkg::STATUS_FULL;
        end else begin
          for (i = table_used; i > idx; i--) table_words[i] = table_words[i - 1];
          table_words[idx] = req.value;
          table_used++;
        end
      end
      oale_pkg::OP_REMOVE: begin
        // The old last word stays behind, above the count.
        if (idx >= table_used) begin
          res.status = oale_pkg::STATUS_RANGE;
        end else begin
          for (i = idx; i + 1 < table_used; i++) table_words[i] = table_words[i + 1];
          table_used--;
        end
      end
      oale_pkg::OP_FIND: begin
        res.status = oale_pkg::STATUS_MISS;
        for (i = 0; i < table_used; i++) begin
          if (table_words[i] == req.value) begin
            res.status = oale_pkg::STATUS_OK;
            res.found_index = i[7:0];
            break;
          end
        end
      end
      oale_pkg::OP_CLEAR: table_used = 0;
      default: ;
    endcase
    res.used_count = table_used[8:0];
    return res;
  endfunction

  // Response checking and prediction share one process, so the pop of an expected
  // response always comes before the push of a new one.
  always @(posedge clk_i) begin
    oale_pkg::oale_rsp_t want;
    oale_pkg::oale_rsp_t got;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        rsp_number++;
        if (expected_rsps.size() == 0) begin
          report_error($sformatf("response %0d arrived with no request pending", rsp_number));
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status)
            report_error($sformatf("response %0d status: got %0d, expected %0d",
                                   rsp_number, got.status, want.status));
          if (got.read_value !== want.read_value)
            report_error($sformatf("response %0d read_value: got %08h, expected %08h",
                                   rsp_number, got.read_value, want.read_value));
          if (got.found_index !== want.found_index)
            report_error($sformatf("response %0d found_index: got %0d, expected %0d",
                                   rsp_number, got.found_index, want.found_index));
          if (got.used_count !== want.used_count)
            report_error($sformatf("response %0d used_count: got %0d, expected %0d",
                                   rsp_number, got.used_count, want.used_count));
        end
      end
      if (req_if.valid && req_if.ready) expected_rsps.push_back(apply_table_op(req_if.payload));
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: ready in runs of random length, with a long hold-off on demand.
  initial begin
    int hold_left;
    int run_left;
    bit run_ready;
    int seen_seq;
    hold_left = 0;
    run_left = 0;
    run_ready = 1'b1;
    seen_seq = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_seq != seen_seq) begin
        seen_seq = hold_off_seq;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(99) >= rsp_stall_pct);
          run_left = run_ready ? $urandom_range(1, 16) : $urandom_range(1, 8);
        end
        run_left--;
        rsp_if.ready <= run_ready;
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted. The valid
  // stays high unless a gap between bursts starts here.
  task automatic send_request(input logic [2:0] op, input logic [7:0] idx,
                              input logic [31:0] val);
    oale_pkg::oale_req_t req;
    int                  gap;
    req.opcode = op;
    req.index = idx;
    req.value = val;
    req_if.payload <= req;
    req_if.valid <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    if (sender_gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          req_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Stops offering and waits until every pending response has arrived. The
  // first wait lets the checker record the request taken at this edge.
  task automatic wait_all_responses();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_rsps.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Builds a request that mostly lands on live positions of the table, with
  // values often drawn from a small pool so that finds hit and duplicates appear.
  task automatic send_random_request();
    int unsigned      pick;
    int unsigned      limit;
    logic [2:0]       op;
    logic [7:0]       idx;
    logic [31:0]      val;
    pick = $urandom_range(99);
    if (pick < 24) op = oale_pkg::OP_INSERT;
    else if (pick < 38) op = oale_pkg::OP_REMOVE;
    else if (pick < 52) op = oale_pkg::OP_FIND;
    else if (pick < 66) op = oale_pkg::OP_READ;
    else if (pick < 74) op = oale_pkg::OP_GROW_READ;
    else if (pick < 88) op = oale_pkg::OP_GROW_WRITE;
    else if (pick < 92) op = oale_pkg::OP_CLEAR;
    else if (pick < 94) op = OP_UNUSED;
    else op = oale_pkg::OP_INSERT;

    limit = (table_used > 255) ? 255 : table_used;
    if (table_used == 0 || $urandom_range(99) < 15) idx = 8'($urandom_range(255));
    else if ((op == oale_pkg::OP_GROW_READ || op == oale_pkg::OP_GROW_WRITE) &&
             $urandom_range(99) < 30)
      idx = ((limit + 3) > 255) ? 8'd255 : 8'(limit + $urandom_range(3));
    else idx = 8'($urandom_range(limit));

    if (op == oale_pkg::OP_FIND && table_used > 0 && $urandom_range(99) < 50)
      val = table_words[$urandom_range(table_used - 1)];
    else if ($urandom_range(99) < 50) val = value_pool[$urandom_range(7)];
    else val = $urandom;
    send_request(op, idx, val);
  endtask

  task automatic run_random_requests(input int count);
    repeat (count) send_random_request();
  endtask

  // Edge cases by hand: empty table, shifting, the full table, stale words
  // above the count, the unused opcode and clear.
  task automatic test_directed();
    sender_gaps_on = 1'b1;
    rsp_stall_pct <= 20;
    send_request(oale_pkg::OP_READ,       8'd0,   32'h0000_0000);  // read on an empty table
    send_request(oale_pkg::OP_FIND,       8'd0,   32'h0000_0000);  // find with nothing in use
    send_request(oale_pkg::OP_REMOVE,     8'd0,   32'h0000_0000);  // remove past the count
    send_request(oale_pkg::OP_INSERT,     8'd1,   32'h1111_1111);  // insert past the count
    send_request(oale_pkg::OP_INSERT,     8'd0,   32'hFFFF_FFFF);
    send_request(oale_pkg::OP_INSERT,     8'd1,   32'h0000_0000);  // append at the count
    send_request(oale_pkg::OP_INSERT,     8'd0,   32'h1234_5678);  // shifts both words up
    send_request(oale_pkg::OP_READ,       8'd0,   32'h0000_0000);
    send_request(oale_pkg::OP_READ,       8'd2,   32'h0000_0000);
    send_request(oale_pkg::OP_FIND,       8'd0,   32'h0000_0000);
    // Remove leaves the old last word behind; grow-read makes it visible again.
    send_request(oale_pkg::OP_REMOVE,     8'd1,   32'h0000_0000);
    send_request(oale_pkg::OP_GROW_READ,  8'd2,   32'h0000_0000);
    send_request(oale_pkg::OP_GROW_WRITE, 8'd255, 32'hA5A5_A5A5);  // table becomes full
    send_request(oale_pkg::OP_INSERT,     8'd255, 32'h5A5A_5A5A);  // full
    send_request(oale_pkg::OP_INSERT,     8'd0,   32'h5A5A_5A5A);  // full
    send_request(oale_pkg::OP_READ,       8'd255, 32'h0000_0000);
    send_request(oale_pkg::OP_GROW_READ,  8'd254, 32'h0000_0000);
    send_request(oale_pkg::OP_REMOVE,     8'd255, 32'h0000_0000);
    // Miss: the word now sits above the count.
    send_request(oale_pkg::OP_FIND,       8'd255, 32'hA5A5_A5A5);
    send_request(oale_pkg::OP_GROW_READ,  8'd255, 32'h0000_0000);
    send_request(OP_UNUSED,               8'd170, 32'h5555_AAAA);
    send_request(oale_pkg::OP_CLEAR,      8'd85,  32'hAAAA_5555);
    send_request(oale_pkg::OP_READ,       8'd0,   32'h0000_0000);
    send_request(oale_pkg::OP_GROW_READ,  8'd0,   32'h0000_0000);
    wait_all_responses();
  endtask

  task automatic test_random_free_flow();
    sender_gaps_on = 1'b0;
    rsp_stall_pct <= 0;
    run_random_requests(100);
    wait_all_responses();
  endtask

  task automatic test_random_stalled();
    sender_gaps_on = 1'b1;
    rsp_stall_pct <= 60;
    run_random_requests(140);
    wait_all_responses();
  endtask

  // The receiver holds off while requests keep coming, so the engine fills
  // and its request side stalls.
  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    rsp_stall_pct <= 0;
    hold_off_seq <= hold_off_seq + 1;
    repeat (3) send_request(oale_pkg::OP_CLEAR, 8'd0, 32'h0);
    run_random_requests(13);
    wait_all_responses();
  endtask

  // The sender stops until every response is back, then resumes.
  task automatic test_pause_and_resume();
    sender_gaps_on = 1'b1;
    rsp_stall_pct <= 30;
    run_random_requests(20);
    wait_all_responses();
    run_random_requests(20);
    wait_all_responses();
  endtask

  task automatic test_random_mixed();
    sender_gaps_on = 1'b1;
    rsp_stall_pct <= 25;
    run_random_requests(100);
    wait_all_responses();
  endtask

  initial begin
    error_count = 0;
    rsp_number = 0;
    table_used = 0;
    burst_left = 0;
    sender_gaps_on = 1'b0;
    rsp_stall_pct = 0;
    hold_off_seq = 0;
    foreach (table_words[k]) table_words[k] = '0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 8; k++) value_pool[k] = $urandom;
    rst_ni = 1'b0;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_free_flow();
    test_random_stalled();
    test_backpressure();
    test_pause_and_resume();
    test_random_mixed();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_rsps.size() != 0)
      report_error($sformatf("%0d responses never arrived", expected_rsps.size()));
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
